/* rtl/slc_pkg.sv */
package slc_pkg;

    localparam int FRAME_W   = 64;
    localparam int MASK_W    = 32;
    localparam int MAX_COORDS = 32;
    localparam int OUT_IDX_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } slc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;         // latch frame, rewind scan
        logic scan;          // issue the next table read
        logic capture_hit;   // take the matching entry's index as result
        logic capture_miss;  // append the frame or flag a full table
        logic load_out;      // move the result into the output register
    } slc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;           // entry under compare matches the frame
        logic exhausted;     // every stored entry compared, none matched
    } slc_status_t;

endpackage

/* rtl/slc_ctrl.sv */
module slc_ctrl
    import slc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  slc_status_t status,
    output slc_cmd_t    cmd
);

    slc_state_t state_reg;
    slc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.capture_hit = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (status.exhausted)
                begin
                    cmd.capture_miss = 1'b1;
                    state_next       = ST_DONE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/slc_dp.sv */
module slc_dp
    import slc_pkg::*;
#(
    parameter int NUM_COORDS   = 32,
    parameter int MAX_CLUSTERS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [MASK_W-1:0]    wr_data,
    input  logic [FRAME_W-1:0]   frame_codes,
    input  slc_cmd_t             cmd,
    output slc_status_t          status,
    output logic [OUT_IDX_W-1:0] cluster_index,
    output logic                 new_cluster,
    output logic                 table_full
);

    localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW = $clog2(MAX_CLUSTERS + 1);

    logic [FRAME_W-1:0] sig_mem [MAX_CLUSTERS];

    logic [MASK_W-1:0]  ignore_mask_reg;
    logic [CW-1:0]      count_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] cmp_mask_reg;
    logic [FRAME_W-1:0] cmp_mask_next;
    logic [CW-1:0]      scan_addr_reg;
    logic [FRAME_W-1:0] rd_data_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [IW-1:0]      res_idx_reg;
    logic               res_new_reg;
    logic               res_full_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic               out_new_reg;
    logic               out_full_reg;
    logic               room;
    logic               mem_we;

    // expand the ignore mask to a per-bit compare mask
    always_comb
    begin
        cmp_mask_next = '0;
        for (int j = 0; j < MAX_COORDS; j++)
        begin
            if (j < NUM_COORDS)
            begin
                cmp_mask_next[2*j]   = ~ignore_mask_reg[j];
                cmp_mask_next[2*j+1] = ~ignore_mask_reg[j];
            end
        end
    end

    assign rd_valid_next    = cmd.scan && (scan_addr_reg != count_reg);
    assign status.hit       = rd_valid_reg &&
                              (((rd_data_reg ^ frame_reg) & cmp_mask_reg) == '0);
    assign status.exhausted = !rd_valid_reg && (scan_addr_reg == count_reg);
    assign room             = (count_reg != CW'(MAX_CLUSTERS));
    assign mem_we           = cmd.capture_miss && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_mask_reg <= '0;
            count_reg       <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                ignore_mask_reg <= wr_data;
            if (mem_we)
                count_reg <= count_reg + 1'b1;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // scan pointer and frame latch
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            frame_reg     <= frame_codes;
            cmp_mask_reg  <= cmp_mask_next;
            scan_addr_reg <= '0;
        end
        else if (rd_valid_next)
        begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (rd_valid_next)
            rd_idx_reg <= scan_addr_reg[IW-1:0];
    end

    // signature table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sig_mem[count_reg[IW-1:0]] <= frame_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_next)
            rd_data_reg <= sig_mem[scan_addr_reg[IW-1:0]];
    end

    // result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_hit)
        begin
            res_idx_reg  <= rd_idx_reg;
            res_new_reg  <= 1'b0;
            res_full_reg <= 1'b0;
        end
        else if (cmd.capture_miss)
        begin
            res_idx_reg  <= room ? count_reg[IW-1:0] : '0;
            res_new_reg  <= room;
            res_full_reg <= !room;
        end
        if (cmd.load_out)
        begin
            out_idx_reg  <= OUT_IDX_W'(res_idx_reg);
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign cluster_index = out_idx_reg;
    assign new_cluster   = out_new_reg;
    assign table_full    = out_full_reg;

endmodule

/* rtl/signature_leader_clustering.sv */
// Leader clustering of frame signatures by exact match on the coordinates not ignored.
// Input channel: in_valid / in_stall with frame_codes (32 coordinates of a
// 2-bit peak code). A transaction is taken when in_valid is high and in_stall
// low. Output channel: out_valid / out_stall with cluster_index, new_cluster
// and table_full, one output transaction for each input transaction.
// Config: wr_en / wr_data write ignore_mask; write only while the block idles.
// Search: one frame walks the signature table one entry per cycle through the
// single read port of the table memory, with the compare in the cycle after the
// read. The walk stops at the first matching entry, or, for a frame that matches
// nothing, once all stored clusters (up to MAX_CLUSTERS) are compared; then the
// result is handed to the output register. One frame is in work at a time;
// in_stall stays high from accept until the result is handed to the output
// register, so the block takes no new frame before it is through with the last.
// The output register holds a finished result while the receiver stalls; the
// next frame may be accepted and searched meanwhile, and its result waits until
// the register frees up.
// Reset clears the cluster count, ignore_mask and the valid flags; the table
// contents need no clearing since only entries below the count are read.
module signature_leader_clustering
    import slc_pkg::*;
#(
    parameter int NUM_COORDS   = 32,
    parameter int MAX_CLUSTERS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [MASK_W-1:0]    wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FRAME_W-1:0]   frame_codes,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_IDX_W-1:0] cluster_index,
    output logic                 new_cluster,
    output logic                 table_full
);

    slc_cmd_t    cmd;
    slc_status_t status;

    // sequencer: idle, table walk, result hand-off
    slc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // table memory, masked compare, cluster count and result registers
    slc_dp #(
        .NUM_COORDS   (NUM_COORDS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .frame_codes   (frame_codes),
        .cmd           (cmd),
        .status        (status),
        .cluster_index (cluster_index),
        .new_cluster   (new_cluster),
        .table_full    (table_full)
    );

endmodule

/* sim/cluster_assign_checker.sv */
`timescale 1ns / 100ps

module cluster_assign_checker
    import slc_pkg::*;
#(
    parameter int NUM_COORDS   = 32,
    parameter int MAX_CLUSTERS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [MASK_W-1:0]    wr_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [FRAME_W-1:0]   frame_codes,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [OUT_IDX_W-1:0] cluster_index,
    input  logic                 new_cluster,
    input  logic                 table_full,
    output int                   mismatch_count,
    output int                   assignments_pending
);

    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic                 created;
        logic                 full;
    } cluster_result_t;

    logic [FRAME_W-1:0] leader_sigs [MAX_CLUSTERS];
    int                 leader_count;
    logic [MASK_W-1:0]  ignored_coords;
    cluster_result_t    expected_assignments [$];

    function automatic logic [FRAME_W-1:0] compared_bits();
        logic [FRAME_W-1:0] care;
        care = '0;
        for (int j = 0; j < NUM_COORDS && j < MAX_COORDS; j++)
            if (!ignored_coords[j])
                care[2*j +: 2] = 2'b11;
        return care;
    endfunction

    // First leader that agrees on every compared coordinate wins; otherwise
    // append the frame as a new leader, or flag a full table.
    function automatic cluster_result_t classify_frame(logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] care;
        cluster_result_t    res;
        bit                 hit;
        care = compared_bits();
        res  = '0;
        hit  = 0;
        for (int k = 0; k < leader_count && !hit; k++)
            if (((leader_sigs[k] ^ frame) & care) == '0) begin
                res.idx = OUT_IDX_W'(k);
                hit     = 1;
            end
        if (!hit) begin
            if (leader_count < MAX_CLUSTERS) begin
                leader_sigs[leader_count] = frame;
                res.idx     = OUT_IDX_W'(leader_count);
                res.created = 1'b1;
                leader_count++;
            end
            else
                res.full = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cluster_result_t want;
        if (!rst_n) begin
            leader_count   = 0;
            ignored_coords = '0;
            expected_assignments.delete();
            mismatch_count = 0;
        end
        else begin
            if (wr_en)
                ignored_coords = wr_data;
            if (in_valid && !in_stall)
                expected_assignments.push_back(classify_frame(frame_codes));
            if (out_valid && !out_stall) begin
                if (expected_assignments.size() == 0) begin
                    $display("%0t: unexpected result index %0d new %0b full %0b",
                             $realtime, cluster_index, new_cluster, table_full);
                    mismatch_count++;
                end
                else begin
                    want = expected_assignments.pop_front();
                    if (cluster_index !== want.idx) begin
                        $display("%0t: cluster_index expected %0d actual %0d",
                                 $realtime, want.idx, cluster_index);
                        mismatch_count++;
                    end
                    if (new_cluster !== want.created) begin
                        $display("%0t: new_cluster expected %0b actual %0b",
                                 $realtime, want.created, new_cluster);
                        mismatch_count++;
                    end
                    if (table_full !== want.full) begin
                        $display("%0t: table_full expected %0b actual %0b",
                                 $realtime, want.full, table_full);
                        mismatch_count++;
                    end
                end
            end
        end
        assignments_pending = expected_assignments.size();
    end

    final
    begin
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb
    import slc_pkg::*;
;

    localparam int NUM_COORDS    = 32;
    localparam int MAX_CLUSTERS  = 256;
    localparam int STALL_LIMIT   = 5000;   // cycles without any transaction
    localparam int LONG_HOLD     = 700;    // receiver hold-off, well past one search
    localparam int DRAIN_CYCLES  = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [MASK_W-1:0]    wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [FRAME_W-1:0]   frame_codes;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_IDX_W-1:0] cluster_index;
    logic                 new_cluster;
    logic                 table_full;

    int                   errors;
    int                   pending;
    int                   idle_cycles;

    logic [FRAME_W-1:0]   sent_frames [$];   // frames offered so far, for repeats
    logic [MASK_W-1:0]    cur_mask;
    int                   frames_sent;
    bit                   steady;            // sender runs without gaps
    bit                   hold_req;          // ask the receiver for a long hold-off

    signature_leader_clustering #(
        .NUM_COORDS   (NUM_COORDS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame_codes   (frame_codes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cluster_index (cluster_index),
        .new_cluster   (new_cluster),
        .table_full    (table_full)
    );

    cluster_assign_checker #(
        .NUM_COORDS   (NUM_COORDS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .wr_en               (wr_en),
        .wr_data             (wr_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .frame_codes         (frame_codes),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .cluster_index       (cluster_index),
        .new_cluster         (new_cluster),
        .table_full          (table_full),
        .mismatch_count      (errors),
        .assignments_pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        return {$urandom, $urandom};
    endfunction

    // Widen a per-coordinate mask to the two code bits of each coordinate.
    function automatic logic [FRAME_W-1:0] spread_mask(logic [MASK_W-1:0] m);
        logic [FRAME_W-1:0] wide;
        wide = '0;
        for (int j = 0; j < MASK_W; j++)
            wide[2*j +: 2] = {2{m[j]}};
        return wide;
    endfunction

    function automatic logic [FRAME_W-1:0] old_frame();
        return sent_frames[$urandom_range(0, sent_frames.size() - 1)];
    endfunction

    // Mix of repeats (some disturbed only in ignored coordinates, so they
    // still match), near misses with one flipped bit, and fresh signatures.
    function automatic logic [FRAME_W-1:0] mixed_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return old_frame() ^ (rand_frame() & spread_mask(cur_mask));
        if (r < 60)
            return old_frame() ^ (64'd1 << $urandom_range(0, FRAME_W - 1));
        return rand_frame();
    endfunction

    // Offer one frame and hold it until the transaction is taken. Leave valid
    // high on return so back-to-back frames need no extra cycle.
    task automatic send_frame(logic [FRAME_W-1:0] frame);
        int gap;
        if (frames_sent % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_codes <= frame;
        sent_frames.push_back(frame);
        frames_sent++;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Write the ignore mask only once every result is back and the block idles.
    task automatic set_ignore_mask(logic [MASK_W-1:0] m);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        wr_en    <= 1'b1;
        wr_data  <= m;
        cur_mask = m;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic run_mixed_phase(logic [MASK_W-1:0] m, int count);
        set_ignore_mask(m);
        for (int i = 0; i < count; i++)
            send_frame(mixed_frame());
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[signature_leader_clustering] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int fresh;
        rst_n       = 1'b0;
        wr_en       = 1'b0;
        wr_data     = '0;
        in_valid    = 1'b0;
        frame_codes = '0;
        cur_mask    = '0;
        frames_sent = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: mask at reset value, first frame founds cluster 0,
        // extremes of the code field, and repeats of some of them.
        send_frame('0);
        send_frame('0);
        send_frame('1);
        send_frame(64'h5555_5555_5555_5555);
        send_frame(64'hAAAA_AAAA_AAAA_AAAA);
        send_frame('1);
        send_frame(64'h0000_0000_0000_0001);
        send_frame(64'hC000_0000_0000_0000);
        send_frame(64'h0000_0000_0000_0001);

        // Every coordinate ignored: everything lands in cluster 0.
        set_ignore_mask('1);
        send_frame(rand_frame());
        send_frame(rand_frame());

        // Lowest and highest coordinate ignored on their own.
        set_ignore_mask(32'h0000_0001);
        send_frame(64'h0000_0000_0000_0002);
        send_frame(64'hAAAA_AAAA_AAAA_AAA9);
        set_ignore_mask(32'h8000_0000);
        send_frame(64'h1555_5555_5555_5555);

        // Random phases while the table grows; the second one opens with a
        // long receiver hold-off, requested once the mask is written, so the
        // block backs up onto its input.
        run_mixed_phase('0, 30);
        set_ignore_mask($urandom);
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_frame(mixed_frame());
        run_mixed_phase($urandom & $urandom & $urandom, 30);
        run_mixed_phase(~($urandom & $urandom & $urandom), 30);

        // Fill the table with fresh signatures, interleaving repeats that
        // hit deep entries, then overflow it.
        set_ignore_mask('0);
        fresh = 0;
        while (fresh < 260)
        begin
            if ($urandom_range(0, 5) == 0)
                send_frame(old_frame());
            else
            begin
                send_frame(rand_frame());
                fresh++;
            end
        end

        // Full table under several masks: hits still resolve, misses flag full.
        run_mixed_phase($urandom, 30);
        run_mixed_phase(~($urandom & $urandom), 30);
        run_mixed_phase('0, 30);

        // Drain and give the verdict.
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[signature_leader_clustering] OK");
        else
            $display("[signature_leader_clustering] ERROR");
        $finish;
    end

endmodule
